>>> rtl/mahd_pkg.sv
// Shared types and constants for the moving average hysteresis detector.
// No dependencies; imported by the top level and the testbench.
package mahd_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] DARK_RESET  = 12'd1200;
   localparam logic [SAMPLE_W-1:0] LIGHT_RESET = 12'd1800;

   typedef enum logic {
      REG_DARK  = 1'b0,
      REG_LIGHT = 1'b1
   } reg_index_type;

endpackage

>>> rtl/mahd_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies; used by the top level as its shared divide unit.
module mahd_divider #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int COUNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff   <= dividend;
            div_ff   <= divisor;
            rem_ff   <= '0;
            count_ff <= COUNT_W'(DIVIDEND_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            quo_ff   <= {quo_ff[DIVIDEND_W-2:0], fits};
            rem_ff   <= rem_in;
            count_ff <= count_ff - 1'b1;
            if (count_ff == COUNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/moving_average_hysteresis_detector.sv
// Top level of the moving average hysteresis detector.
// Depends on mahd_pkg and mahd_divider.
//
// Usage:
//   req channel: one 12-bit light sample per beat in req_tdata[11:0].
//   rsp channel: one result beat per sample: rsp_tdata[11:0] average,
//   [12] indicator_on, [13] indicator_changed.
//   csr port: APB-style, dark threshold at 0x0, light threshold at 0x4.
// Each sample passes through S_UPDATE, which updates the ring and total and
// starts the shared bit-serial divider, S_DIVIDE, which waits for its done
// flag, and S_FINISH, which loads the result. req_tready stays low until the
// sequencer is back in S_IDLE, so a new sample is not taken before the last
// one has been through the divider and its result loaded.
// The result register is separate from the sequencer, so the next sample is
// taken while a result waits; if rsp_tready stays low, the sequencer holds
// the next result until the register frees.
// Reset (synchronous, active high) empties the window, zeroes the total,
// clears the indicator and restores thresholds 1200 and 1800. The ring needs
// no clearing pass: an entry's old value is used only once the window is full.
module moving_average_hysteresis_detector import mahd_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] average, [12] indicator_on,
                                              // [13] indicator_changed
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int TOTAL_W = SAMPLE_W + CNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type              state_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [CNT_W-1:0]       fill_ff;
   logic [CNT_W-1:0]       fill_in;
   logic [TOTAL_W-1:0]     total_ff;
   logic [TOTAL_W-1:0]     total_in;
   logic                   flag_ff;
   logic                   flag_in;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic [SAMPLE_W-1:0]    old_ff;
   logic [SAMPLE_W-1:0]    dark_ff;
   logic [SAMPLE_W-1:0]    light_ff;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [SAMPLE_W-1:0]    ring [WINDOW];
   logic                   full;
   logic                   req_beat;
   logic                   csr_write;
   logic                   div_start;
   logic                   div_done;
   logic [TOTAL_W-1:0]     quotient;
   logic [SAMPLE_W-1:0]    average;
   reg_index_type          csr_index;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign full       = (fill_ff == CNT_W'(WINDOW));
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      fill_in  = full ? fill_ff : fill_ff + 1'b1;
      total_in = total_ff - (full ? TOTAL_W'(old_ff) : '0) + TOTAL_W'(sample_ff);
      average  = quotient[SAMPLE_W-1:0];
      flag_in  = flag_ff;
      if (!flag_ff && (average < dark_ff)) begin
         flag_in = 1'b1;
      end else if (flag_ff && (average > light_ff)) begin
         flag_in = 1'b0;
      end
   end

   always_comb begin
      case (csr_index)
         REG_DARK:  csr_prdata = CSR_DATA_W'(dark_ff);
         REG_LIGHT: csr_prdata = CSR_DATA_W'(light_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (req_beat) begin
         old_ff <= ring[slot_ff];
      end
      if (state_ff == S_UPDATE) begin
         ring[slot_ff] <= sample_ff;
      end
   end

   assign div_start = (state_ff == S_UPDATE);

   mahd_divider #(
      .DIVIDEND_W (TOTAL_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         total_ff     <= '0;
         flag_ff      <= 1'b0;
         dark_ff      <= DARK_RESET;
         light_ff     <= LIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_DARK:  dark_ff  <= csr_pwdata[SAMPLE_W-1:0];
               REG_LIGHT: light_ff <= csr_pwdata[SAMPLE_W-1:0];
               default:   ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  sample_ff <= req_tdata[SAMPLE_W-1:0];
                  state_ff  <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               total_ff <= total_in;
               fill_ff  <= fill_in;
               slot_ff  <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               if (div_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_DATA_W'({flag_in != flag_ff, flag_in, average});
                  flag_ff      <= flag_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count beyond window");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("write slot beyond window");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVIDE)
      else $error("divider finished outside divide phase");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == S_UPDATE)
      else $error("accepted sample not taken to update");
`endif

endmodule

>>> verif/mahd_average_checker.sv
`timescale 1ns / 100ps
// Checker for the moving average hysteresis detector: watches the sample, result and
// register ports, predicts each result and compares it with the beat seen on rsp.
// Depends on mahd_pkg; instantiated by moving_average_hysteresis_detector_test.
module mahd_average_checker import mahd_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    results_pending
);

   typedef struct packed {
      logic                indicator_changed;
      logic                indicator_on;
      logic [SAMPLE_W-1:0] average;
   } light_result_type;

   logic [SAMPLE_W-1:0] window_samples [WINDOW];
   int unsigned         next_slot;
   int unsigned         samples_held;
   int unsigned         window_total;
   logic                dark_flag;
   logic [SAMPLE_W-1:0] dark_level;
   logic [SAMPLE_W-1:0] light_level;
   light_result_type    expected_results [$];

   function automatic light_result_type advance_window(input logic [SAMPLE_W-1:0] sample);
      light_result_type result;
      logic             was_dark;
      was_dark = dark_flag;
      if (samples_held >= WINDOW) begin
         window_total -= window_samples[next_slot];
      end else begin
         samples_held++;
      end
      window_samples[next_slot] = sample;
      window_total += sample;
      next_slot = (next_slot + 1) % WINDOW;
      result.average = SAMPLE_W'(window_total / samples_held);
      if (!dark_flag && result.average < dark_level) begin
         dark_flag = 1'b1;
      end else if (dark_flag && result.average > light_level) begin
         dark_flag = 1'b0;
      end
      result.indicator_on      = dark_flag;
      result.indicator_changed = dark_flag != was_dark;
      return result;
   endfunction

   always @(posedge clock) begin
      light_result_type                seen;
      light_result_type                want;
      logic            [CSR_DATA_W-1:0] read_value;
      if (reset) begin
         next_slot    = 0;
         samples_held = 0;
         window_total = 0;
         dark_flag    = 1'b0;
         dark_level   = DARK_RESET;
         light_level  = LIGHT_RESET;
         fail_count   = 0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
                  REG_DARK: begin
                     dark_level = csr_pwdata[SAMPLE_W-1:0];
                  end
                  REG_LIGHT: begin
                     light_level = csr_pwdata[SAMPLE_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end else begin
               case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
                  REG_DARK:  read_value = CSR_DATA_W'(dark_level);
                  REG_LIGHT: read_value = CSR_DATA_W'(light_level);
                  default:   read_value = '0;
               endcase
               if (csr_prdata !== read_value) begin
                  $display("%0t: register read at %0h: expected %0d, actual %0d",
                           $time, csr_paddr, read_value, csr_prdata);
                  fail_count++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = light_result_type'(rsp_tdata[$bits(light_result_type)-1:0]);
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual %0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (seen.average !== want.average) begin
                  $display("%0t: average: expected %0d, actual %0d",
                           $time, want.average, seen.average);
                  fail_count++;
               end
               if (seen.indicator_on !== want.indicator_on) begin
                  $display("%0t: indicator_on: expected %0b, actual %0b",
                           $time, want.indicator_on, seen.indicator_on);
                  fail_count++;
               end
               if (seen.indicator_changed !== want.indicator_changed) begin
                  $display("%0t: indicator_changed: expected %0b, actual %0b",
                           $time, want.indicator_changed, seen.indicator_changed);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(advance_window(req_tdata[SAMPLE_W-1:0]));
         end
      end
      results_pending = expected_results.size();
   end

endmodule

>>> verif/moving_average_hysteresis_detector_test.sv
`timescale 1ns / 100ps
// Testbench top for the moving average hysteresis detector: drives samples, result
// back-pressure and threshold writes, and reports the verdict from the checker.
// Depends on mahd_pkg, moving_average_hysteresis_detector and mahd_average_checker.
module moving_average_hysteresis_detector_test;
   import mahd_pkg::*;

   localparam int WINDOW        = 10;
   localparam int PHASES        = 8;
   localparam int PHASE_BEATS   = 240;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 30;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [11:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [11:0] average, [12] indicator_on,
                                              // [13] indicator_changed
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int results_pending;
   int idle_cycles = 0;
   bit send_eager  = 1'b0;
   bit take_eager  = 1'b0;
   int scene_level = 2000;

   moving_average_hysteresis_detector #(.WINDOW(WINDOW)) dut (.*);

   mahd_average_checker #(.WINDOW(WINDOW)) average_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = take_eager ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = send_eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(sample);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic csr_access(input reg_index_type index, input logic write,
                             input logic [SAMPLE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {20'($urandom), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] scene_sample(input int beat);
      int value;
      if (beat % 30 == 0) begin
         scene_level = $urandom_range(0, 4095);
      end
      case ($urandom_range(0, 9))
         0: value = $urandom_range(0, 4095);
         1: value = $urandom_range(0, 1) ? 4095 : 0;
         default: begin
            scene_level += $urandom_range(0, 300) - 150;
            if (scene_level < 0) scene_level = 0;
            if (scene_level > 4095) scene_level = 4095;
            value = scene_level + $urandom_range(0, 400) - 200;
         end
      endcase
      if (value < 0) value = 0;
      if (value > 4095) value = 4095;
      return SAMPLE_W'(value);
   endfunction

   initial begin
      logic [SAMPLE_W-1:0] dark_setting;
      logic [SAMPLE_W-1:0] light_setting;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      csr_access(REG_DARK, 1'b0, '0);
      csr_access(REG_LIGHT, 1'b0, '0);

      // warm-up from a single dark sample, full-scale window, wrap back to zero
      send_sample(12'd0);
      repeat (10) send_sample(12'hFFF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      repeat (10) send_sample(12'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin dark_setting = 12'd1200; light_setting = 12'd1800; end
            1: begin dark_setting = 12'd0;    light_setting = 12'd4095; end
            2: begin dark_setting = 12'd4095; light_setting = 12'd0;    end
            3: begin dark_setting = 12'd0;    light_setting = 12'd0;    end
            4: begin dark_setting = 12'd4095; light_setting = 12'd4095; end
            5: begin dark_setting = 12'd3000; light_setting = 12'd1000; end
            default: begin
               dark_setting  = SAMPLE_W'($urandom_range(200, 2000));
               light_setting = SAMPLE_W'(dark_setting + $urandom_range(0, 1500));
            end
         endcase
         csr_access(REG_DARK, 1'b1, dark_setting);
         csr_access(REG_LIGHT, 1'b1, light_setting);
         csr_access(REG_DARK, 1'b0, '0);
         csr_access(REG_LIGHT, 1'b0, '0);
         for (int beat = 0; beat < PHASE_BEATS; beat++) begin
            if (beat % 60 == 0) begin
               send_eager = (phase % 3 == 1) || ($urandom_range(0, 3) == 0);
               take_eager = (phase % 3 == 1) || ($urandom_range(0, 3) == 0);
            end
            send_sample(scene_sample(beat));
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
